### sv/usbsp_pkg.sv
// Package for the endpoint descriptor speed patcher.
// Holds beat payload types, descriptor constants and the bInterval helpers.
// No dependencies.
package usbsp_pkg;

  localparam logic [15:0] POS_TLEN_LO  = 16'd2;
  localparam logic [15:0] POS_TLEN_HI  = 16'd3;
  localparam logic [15:0] HDR_BYTES    = 16'd4;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [7:0] OFF_LENGTH    = 8'd0;
  localparam logic [7:0] OFF_TYPE      = 8'd1;
  localparam logic [7:0] OFF_ATTR      = 8'd3;
  localparam logic [7:0] OFF_MPS_LO    = 8'd4;
  localparam logic [7:0] OFF_MPS_HI    = 8'd5;
  localparam logic [7:0] OFF_INTERVAL  = 8'd6;

  localparam logic [7:0] DESC_ENDPOINT = 8'd5;
  localparam logic [7:0] EP_MIN_LEN    = 8'd7;

  localparam logic [15:0] BULK_MPS     = 16'd512;
  localparam logic [8:0]  ISO_ADD      = 9'd3;
  localparam logic [8:0]  INTERVAL_MAX = 9'd16;

  localparam logic [2:0] SPEED_RESET   = 3'd2;
  localparam logic [2:0] SPEED_HIGH    = 3'd3;

  typedef enum logic [1:0] {
    EP_CONTROL   = 2'd0,
    EP_ISOC      = 2'd1,
    EP_BULK      = 2'd2,
    EP_INTERRUPT = 2'd3
  } ep_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_config;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_patched;
    logic       end_of_config;
  } out_item_t;

  // min(d + 3, 16)
  function automatic logic [7:0] iso_interval(input logic [7:0] d);
    logic [8:0] sum;
    sum = {1'b0, d} + ISO_ADD;
    return (sum < INTERVAL_MAX) ? sum[7:0] : INTERVAL_MAX[7:0];
  endfunction

  // smallest i in 1..16 with 2^(i-1) >= 8*d, else 16
  function automatic logic [7:0] int_interval(input logic [7:0] d);
    logic [16:0] frames;
    logic [7:0]  r;
    frames = {6'b0, d, 3'b000};
    r = INTERVAL_MAX[7:0];
    for (int i = 16; i >= 1; i--) begin
      if ((17'd1 << (i - 1)) >= frames) begin
        r = 8'(i);
      end
    end
    return r;
  endfunction

endpackage

### sv/usbsp_ifs.sv
// Valid/ready channel interfaces for the speed patcher.
// Input beats carry descriptor bytes, output beats carry patched bytes.
interface usbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_config;

  modport source(output valid, output data_byte, output start_of_config, input ready);
  modport sink(input valid, input data_byte, input start_of_config, output ready);
endinterface

interface usbsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       was_patched;
  logic       end_of_config;

  modport source(output valid, output out_byte, output was_patched, output end_of_config,
                 input ready);
  modport sink(input valid, input out_byte, input was_patched, input end_of_config,
               output ready);
endinterface

### sv/usb_endpoint_descriptor_speed_patcher.sv
// Each beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the output is ready; a beat is taken while the
// result register waits only as long as the input register is free.
// Reset (rst, synchronous): empties both registers, clears the parse state and
// sets device_speed to full speed. Depends on usbsp_pkg, usbsp_ifs, usbsp_in_stage, usbsp_patch.
module usb_endpoint_descriptor_speed_patcher (
  input  logic       clk,
  input  logic       rst,
  usbsp_in_if.sink   in,
  usbsp_out_if.source out,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);
  import usbsp_pkg::*;

  logic      stage_valid;
  logic      advance;
  in_item_t  item;
  out_item_t result;
  logic      out_valid;
  out_item_t out_item;
  logic [2:0] device_speed;

  assign advance = stage_valid && (!out_valid || out.ready);

  usbsp_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in          (in),
    .advance     (advance),
    .stage_valid (stage_valid),
    .item        (item)
  );

  usbsp_patch u_patch (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item),
    .device_speed (device_speed),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      device_speed <= SPEED_RESET;
    end else if (cfg_wr_en) begin
      device_speed <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign out.valid         = out_valid;
  assign out.out_byte      = out_item.out_byte;
  assign out.was_patched   = out_item.was_patched;
  assign out.end_of_config = out_item.end_of_config;

  a_patch_needs_low_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.was_patched |-> device_speed < SPEED_HIGH)
    else $error("byte patched at high speed or above");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> stage_valid && out_valid)
    else $error("input stalled with room in the pipeline");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("beat lost between stages");

endmodule

### sv/usbsp_in_stage.sv
// Input register of the speed patcher: captures one beat per cycle while free or emptying.
// Depends on usbsp_pkg and usbsp_in_if.
module usbsp_in_stage (
  input  logic               clk,
  input  logic               rst,
  usbsp_in_if.sink           in,
  input  logic               advance,
  output logic               stage_valid,
  output usbsp_pkg::in_item_t item
);
  import usbsp_pkg::*;

  logic     valid;
  in_item_t held;

  assign in.ready    = !valid || advance;
  assign stage_valid = valid;
  assign item        = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in.ready) begin
      valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      held <= '{data_byte: in.data_byte, start_of_config: in.start_of_config};
    end
  end

endmodule

### sv/usbsp_patch.sv
// Descriptor walker and patch logic: parse state plus the per-byte rewrite.
// State advances when a beat leaves the input register. Depends on usbsp_pkg.
module usbsp_patch (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  usbsp_pkg::in_item_t  item,
  input  logic [2:0]           device_speed,
  output usbsp_pkg::out_item_t result
);
  import usbsp_pkg::*;

  logic [15:0] byte_position, total_length;
  logic [7:0]  offset_in_descriptor, descriptor_length, descriptor_kind;
  ep_kind_t    endpoint_kind;
  logic        parsing_stopped;

  logic [15:0] byte_position_next, total_length_next;
  logic [7:0]  offset_in_descriptor_next, descriptor_length_next, descriptor_kind_next;
  ep_kind_t    endpoint_kind_next;
  logic        parsing_stopped_next;

  logic [15:0] c_pos, c_tlen;
  logic [7:0]  c_off, c_dlen, c_kind;
  ep_kind_t    c_ep;
  logic        c_stop;

  logic [7:0]  d;
  logic [15:0] desc_start;
  logic [16:0] desc_end;
  logic [8:0]  off_inc;
  logic        ok;
  logic [7:0]  res;
  logic        patched;
  logic        last;

  assign d = item.data_byte;

  // start of a new set sees cleared state
  always_comb begin
    if (item.start_of_config) begin
      c_pos  = '0;
      c_tlen = '0;
      c_off  = '0;
      c_dlen = '0;
      c_kind = '0;
      c_ep   = EP_CONTROL;
      c_stop = 1'b0;
    end else begin
      c_pos  = byte_position;
      c_tlen = total_length;
      c_off  = offset_in_descriptor;
      c_dlen = descriptor_length;
      c_kind = descriptor_kind;
      c_ep   = endpoint_kind;
      c_stop = parsing_stopped;
    end
  end

  always_comb begin
    total_length_next         = c_tlen;
    descriptor_length_next    = c_dlen;
    descriptor_kind_next      = c_kind;
    endpoint_kind_next        = c_ep;
    parsing_stopped_next      = c_stop;
    offset_in_descriptor_next = c_off;
    res                       = d;
    patched                   = 1'b0;
    ok                        = 1'b0;
    off_inc                   = {1'b0, c_off} + 9'd1;
    desc_start                = c_pos - {8'b0, c_off};

    if (c_pos == POS_TLEN_LO) begin
      total_length_next[7:0] = d;
    end else if (c_pos == POS_TLEN_HI) begin
      total_length_next[15:8] = d;
    end

    if (!c_stop) begin
      priority if (c_off == OFF_LENGTH) begin
        if (d == 8'd0) begin
          parsing_stopped_next = 1'b1;
        end else begin
          descriptor_length_next = d;
          descriptor_kind_next   = '0;
          endpoint_kind_next     = EP_CONTROL;
        end
      end else if (c_off == OFF_TYPE) begin
        descriptor_kind_next = d;
      end else if (c_off == OFF_ATTR) begin
        endpoint_kind_next = ep_kind_t'(d[1:0]);
      end else begin
      end
    end

    desc_end = {1'b0, desc_start} + {9'b0, descriptor_length_next};

    if (!parsing_stopped_next) begin
      ok = (device_speed < SPEED_HIGH) && (descriptor_kind_next == DESC_ENDPOINT) &&
           (descriptor_length_next >= EP_MIN_LEN) && ({8'b0, c_off} <= c_pos) &&
           (desc_start >= HDR_BYTES) && (desc_end <= {1'b0, total_length_next});
      if (ok) begin
        unique case (endpoint_kind_next)
          EP_BULK: begin
            if (c_off == OFF_MPS_LO) begin
              res     = BULK_MPS[7:0];
              patched = 1'b1;
            end else if (c_off == OFF_MPS_HI) begin
              res     = BULK_MPS[15:8];
              patched = 1'b1;
            end
          end
          EP_ISOC: begin
            if (c_off == OFF_INTERVAL) begin
              res     = iso_interval(d);
              patched = 1'b1;
            end
          end
          EP_INTERRUPT: begin
            if (c_off == OFF_INTERVAL) begin
              res     = int_interval(d);
              patched = 1'b1;
            end
          end
          EP_CONTROL: begin
          end
        endcase
      end
      offset_in_descriptor_next =
        (off_inc >= {1'b0, descriptor_length_next}) ? 8'd0 : off_inc[7:0];
    end
  end

  assign last = (total_length_next != 16'd0) && (c_pos == total_length_next - 16'd1);
  assign byte_position_next = (c_pos == POS_MAX) ? c_pos : c_pos + 16'd1;

  assign result = '{out_byte: res, was_patched: patched, end_of_config: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      total_length         <= '0;
      offset_in_descriptor <= '0;
      descriptor_length    <= '0;
      descriptor_kind      <= '0;
      endpoint_kind        <= EP_CONTROL;
      parsing_stopped      <= 1'b0;
    end else if (advance) begin
      byte_position        <= byte_position_next;
      total_length         <= total_length_next;
      offset_in_descriptor <= offset_in_descriptor_next;
      descriptor_length    <= descriptor_length_next;
      descriptor_kind      <= descriptor_kind_next;
      endpoint_kind        <= endpoint_kind_next;
      parsing_stopped      <= parsing_stopped_next;
    end
  end

  a_off_in_range: assert property (@(posedge clk) disable iff (rst)
    (offset_in_descriptor == 8'd0) || (offset_in_descriptor < descriptor_length))
    else $error("descriptor offset beyond bLength");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    parsing_stopped && advance && !item.start_of_config |=> parsing_stopped)
    else $error("parsing resumed without a new set");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    (byte_position == POS_MAX) && advance && !item.start_of_config
    |=> byte_position == POS_MAX)
    else $error("byte position wrapped");

endmodule

### bench/patcher_checker.sv
// Checker for the endpoint descriptor speed patcher: watches both beat channels and
// the config port, predicts every output beat and compares it field by field.
// Depends on usbsp_pkg and usbsp_ifs.
module patcher_checker (
  input  logic       clk,
  input  logic       rst,
  usbsp_in_if        in_ch,
  usbsp_out_if       out_ch,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  output int         errors,
  output int         checked,
  output int         patched_seen,
  output int         ends_seen
);
  import usbsp_pkg::*;

  localparam int REPORT_MAX = 10;

  logic [2:0]  speed_q;
  logic [15:0] pos_q;
  logic [15:0] tlen_q;
  logic [7:0]  off_q;
  logic [7:0]  dlen_q;
  logic [7:0]  dkind_q;
  ep_kind_t    ekind_q;
  logic        stopped_q;
  out_item_t   expected_bytes[$];
  int          err_n;
  int          chk_n;
  int          patch_n;
  int          end_n;

  task automatic clear_parse();
    pos_q     = '0;
    tlen_q    = '0;
    off_q     = '0;
    dlen_q    = '0;
    dkind_q   = '0;
    ekind_q   = EP_CONTROL;
    stopped_q = 1'b0;
  endtask

  task automatic predict_patch(input logic [7:0] d, input logic sof, output out_item_t r);
    int base;
    int nxt;
    int sum;
    int frames;
    int k;
    if (sof) begin
      clear_parse();
    end
    r.out_byte      = d;
    r.was_patched   = 1'b0;
    r.end_of_config = 1'b0;
    if (pos_q == POS_TLEN_LO) begin
      tlen_q[7:0] = d;
    end else if (pos_q == POS_TLEN_HI) begin
      tlen_q[15:8] = d;
    end
    if (!stopped_q) begin
      if (off_q == OFF_LENGTH) begin
        if (d == 8'd0) begin
          stopped_q = 1'b1;
        end else begin
          dlen_q  = d;
          dkind_q = '0;
          ekind_q = EP_CONTROL;
        end
      end else if (off_q == OFF_TYPE) begin
        dkind_q = d;
      end else if (off_q == OFF_ATTR) begin
        ekind_q = ep_kind_t'(d[1:0]);
      end
      if (!stopped_q) begin
        // descriptor start must follow wTotalLength and fit inside it
        base = int'(pos_q) - int'(off_q);
        if (speed_q < SPEED_HIGH && dkind_q == DESC_ENDPOINT && dlen_q >= EP_MIN_LEN &&
            base >= int'(HDR_BYTES) && base + int'(dlen_q) <= int'(tlen_q)) begin
          case (ekind_q)
            EP_BULK: begin
              if (off_q == OFF_MPS_LO) begin
                r.out_byte    = BULK_MPS[7:0];
                r.was_patched = 1'b1;
              end else if (off_q == OFF_MPS_HI) begin
                r.out_byte    = BULK_MPS[15:8];
                r.was_patched = 1'b1;
              end
            end
            EP_ISOC: begin
              if (off_q == OFF_INTERVAL) begin
                sum           = int'(d) + int'(ISO_ADD);
                r.out_byte    = (sum < int'(INTERVAL_MAX)) ? 8'(sum) : 8'(INTERVAL_MAX);
                r.was_patched = 1'b1;
              end
            end
            EP_INTERRUPT: begin
              if (off_q == OFF_INTERVAL) begin
                frames = 8 * int'(d);
                k = 1;
                while (k < int'(INTERVAL_MAX) && (1 << (k - 1)) < frames) begin
                  k++;
                end
                r.out_byte    = 8'(k);
                r.was_patched = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        nxt = int'(off_q) + 1;
        off_q = (nxt >= int'(dlen_q)) ? 8'd0 : 8'(nxt);
      end
    end
    r.end_of_config = (tlen_q != 16'd0) && (pos_q == tlen_q - 16'd1);
    if (pos_q != POS_MAX) begin
      pos_q = pos_q + 16'd1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    out_item_t pred;
    if (rst) begin
      clear_parse();
      speed_q = SPEED_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        speed_q = cfg_wr_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte      = out_ch.out_byte;
        got.was_patched   = out_ch.was_patched;
        got.end_of_config = out_ch.end_of_config;
        if (expected_bytes.size() == 0) begin
          if (err_n < REPORT_MAX) begin
            $display("Unexpected output beat: byte %02h patched %0b end %0b",
                     got.out_byte, got.was_patched, got.end_of_config);
          end
          err_n++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte || got.was_patched !== want.was_patched ||
              got.end_of_config !== want.end_of_config) begin
            if (err_n < REPORT_MAX) begin
              $display("Mismatch on output beat %0d: expected byte %02h patched %0b end %0b,",
                       chk_n, want.out_byte, want.was_patched, want.end_of_config);
              $display("  got byte %02h patched %0b end %0b",
                       got.out_byte, got.was_patched, got.end_of_config);
            end
            err_n++;
          end
          chk_n++;
        end
        if (got.was_patched === 1'b1) begin
          patch_n++;
        end
        if (got.end_of_config === 1'b1) begin
          end_n++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_patch(in_ch.data_byte, in_ch.start_of_config, pred);
        expected_bytes.push_back(pred);
      end
    end
    errors       <= err_n;
    checked      <= chk_n;
    patched_seen <= patch_n;
    ends_seen    <= end_n;
  end

endmodule

### bench/testbench.sv
// Top of the speed patcher bench: clock, reset, descriptor stimulus, config writes,
// output stalls, verdict. Uses usbsp_pkg, usbsp_ifs, patcher_checker, the patcher.
module testbench;
  import usbsp_pkg::*;

  localparam int IDLE_PCT    = 38;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  usbsp_in_if  in_ch();
  usbsp_out_if out_ch();

  int         errors;
  int         checked;
  int         patched_seen;
  int         ends_seen;
  int         sent;
  int         sets_sent;
  int         speed_writes;
  int         quiet;
  int         hold_left;
  bit         hold_req;
  bit         gaps_on = 1'b1;
  logic [7:0] set_bytes[$];
  logic [2:0] speed_plan[10] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd0, 3'd6, 3'd1, 3'd4, 3'd2};

  usb_endpoint_descriptor_speed_patcher dut (
    .clk         (clk),
    .rst         (rst),
    .in          (in_ch),
    .out         (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  patcher_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .errors       (errors),
    .checked      (checked),
    .patched_seen (patched_seen),
    .ends_seen    (ends_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // output side: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic sof);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.data_byte       <= d;
    in_ch.start_of_config <= sof;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (checked != sent) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_speed(input logic [2:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    speed_writes++;
  endtask

  task automatic send_set(input logic sof_first);
    foreach (set_bytes[i]) begin
      push_byte(set_bytes[i], (i == 0) && sof_first);
    end
    sets_sent++;
  endtask

  // one descriptor set: config header, then endpoint and other descriptors,
  // with wTotalLength now and then short, long or tiny; some sets are pure noise
  task automatic build_set();
    logic [7:0] desc[12];
    int         len;
    int         tlen;
    int         roll;
    set_bytes.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(40, 1)) set_bytes.push_back(8'($urandom));
      return;
    end
    foreach (desc[i]) desc[i] = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 60) begin
      len = 9;
      desc[OFF_TYPE] = 8'd2;
    end else if (roll < 90) begin
      len = 4;
      desc[OFF_TYPE] = 8'd2;
    end else begin
      len = 7;
      desc[OFF_TYPE] = DESC_ENDPOINT;
    end
    desc[OFF_LENGTH] = 8'(len);
    for (int i = 0; i < len; i++) set_bytes.push_back(desc[i]);
    repeat ($urandom_range(5, 1)) begin
      foreach (desc[i]) desc[i] = 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 65) begin
        len = 7;
        if ($urandom_range(9) == 0) begin
          len = $urandom_range(6, 1);
        end else if ($urandom_range(9) == 0) begin
          len = $urandom_range(12, 8);
        end
        desc[OFF_TYPE] = DESC_ENDPOINT;
        if ($urandom_range(3) != 0) begin
          desc[OFF_INTERVAL] = 8'($urandom_range(20));
        end
        desc[OFF_LENGTH] = 8'(len);
      end else if (roll < 92) begin
        len = $urandom_range(12, 1);
        desc[OFF_LENGTH] = 8'(len);
      end else begin
        len = $urandom_range(4, 1);
        desc[OFF_LENGTH] = 8'd0;
      end
      for (int i = 0; i < len; i++) set_bytes.push_back(desc[i]);
    end
    tlen = set_bytes.size();
    roll = $urandom_range(99);
    if (roll < 8) begin
      tlen = $urandom_range(3);
    end else if (roll < 18) begin
      tlen = $urandom_range(tlen, 4);
    end else if (roll < 28) begin
      tlen += $urandom_range(6, 1);
    end else if (roll < 36) begin
      repeat ($urandom_range(3, 1)) set_bytes.push_back(8'($urandom));
    end
    set_bytes[POS_TLEN_LO] = 8'(tlen);
    set_bytes[POS_TLEN_HI] = 8'(tlen >> 8);
  endtask

  initial begin
    int  start;
    bit  held;
    bit  paused;
    in_ch.valid           = 1'b0;
    in_ch.data_byte       = '0;
    in_ch.start_of_config = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bulk, iso at max bInterval, interrupt with zero bInterval, then a zero bLength
    set_bytes = '{8'd4, 8'd2, 8'd26, 8'd0,
                  8'd7, DESC_ENDPOINT, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
                  8'd7, DESC_ENDPOINT, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                  8'd7, DESC_ENDPOINT, 8'h82, 8'h03, 8'h08, 8'h00, 8'h00,
                  8'h00};
    send_set(1'b1);

    held   = 1'b0;
    paused = 1'b0;
    foreach (speed_plan[ph]) begin
      write_speed(speed_plan[ph]);
      gaps_on = (ph != 5);
      start = sent;
      while (sent - start < PHASE_BYTES) begin
        build_set();
        send_set($urandom_range(19) != 0);
        if (ph == 1 && !held && sent - start > 80) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if (ph == 2 && !paused && sent - start > 80) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (checked != sent) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d descriptor bytes in %0d sets over %0d speed writes.",
             sent, sets_sent, speed_writes);
    $display("Checked %0d output beats: %0d rewritten, %0d end-of-config, %0d mismatches.",
             checked, patched_seen, ends_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/usbsp_pkg.sv
sv/usbsp_ifs.sv
sv/usbsp_in_stage.sv
sv/usbsp_patch.sv
sv/usb_endpoint_descriptor_speed_patcher.sv
bench/patcher_checker.sv
bench/testbench.sv
